// ===== rtl/cpt_pkg.sv =====
// shared constants for the closest-point-on-triangle pipeline
// no dependencies; imported by the multiplier and the top level
`default_nettype none
package cpt_pkg;

  // default coordinate width, signed fixed point
  localparam int CPT_COORD_WIDTH = 32;

  // partial-product passes per multiplier, one register each
  localparam int MUL_STAGES = 4;

endpackage
`default_nettype wire

// ===== rtl/closest_point_on_triangle_3d.sv =====
// top level: closest point on a 3d triangle, fully pipelined
// depends on cpt_pkg, cpt_mul, cpt_div and cpt_dly
//
// One query word is taken every clock cycle (busy stays low) and its answer
// comes out on the out_ ports, marked by out_valid for a single cycle. The
// latency is set by four multiplier passes (the normal, the edge-plane
// vectors, the edge tests with the quotient numerators, and the squared
// distances) and by the divider, which resolves one quotient bit per stage.
// The receiver cannot hold results off, so every answer must be taken in
// the cycle it appears. All arithmetic is exact, the quotients round to
// nearest with ties away from zero, and the answer saturates to the signed
// coordinate range. A triangle with a zero normal always returns the
// nearest edge point.
`default_nettype none
module closest_point_on_triangle_3d import cpt_pkg::*; #(
  parameter int COORD_WIDTH = CPT_COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner0_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner0_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner0_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner1_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner1_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner1_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner2_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner2_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner2_z,
  output logic                               out_valid,
  output logic signed [COORD_WIDTH-1:0]      out_nearest_x,
  output logic signed [COORD_WIDTH-1:0]      out_nearest_y,
  output logic signed [COORD_WIDTH-1:0]      out_nearest_z
);

  // operand widths, all exact
  localparam int W   = COORD_WIDTH;
  localparam int DWD = W + 1;        // coordinate difference
  localparam int NWN = 2 * W + 3;    // normal component
  localparam int DLW = 2 * W + 4;    // segment dot and squared length
  localparam int CW  = 3 * W + 5;    // edge-plane vector component
  localparam int QW  = 3 * W + 6;    // plane offset dot
  localparam int MW  = 4 * W + 8;    // squared normal length
  localparam int SW  = 4 * W + 8;    // edge test sum
  localparam int NEW = 3 * W + 5;    // segment quotient numerator
  localparam int NPW = 5 * W + 9;    // plane quotient numerator
  localparam int QB  = W + 2;        // quotient magnitude bits
  localparam int QOW = QB + 2;       // signed rounded quotient
  localparam int DSW = 2 * W + 4;    // squared distance

  // pipeline timing, in cycles after the input word is taken
  localparam int LM  = MUL_STAGES;
  localparam int LD  = QB + 2;
  localparam int T1  = 1;
  localparam int T2  = T1 + LM + 1;
  localparam int T3  = T2 + LM + 1;
  localparam int T4  = T3 + LM + 1;
  localparam int T4D = T4 + 1;
  localparam int T5  = T4D + LD;
  localparam int T6  = T5 + 1;
  localparam int T7  = T6 + LM + 1;
  localparam int T8  = T7 + 1;

  logic accept;
  logic [T8-1:0] vld_r;

  // never stalls: one word per cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits ride alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[T8-2:0], accept};
    end
  end

  assign out_valid = vld_r[T8-1];

  // ---------------------------------------------------------------------
  // stage 1: edge vectors and point offsets
  // ---------------------------------------------------------------------
  logic [2:0][W-1:0]        pin, p_r;
  logic [2:0][2:0][W-1:0]   vin, v_r;
  logic [2:0][2:0][DWD-1:0] e_nxt, e_r;    // edge k runs from corner k to corner k+1
  logic [2:0][2:0][DWD-1:0] ap_nxt, ap_r;  // point minus corner k

  assign pin    = {in_point_z, in_point_y, in_point_x};
  assign vin[0] = {in_corner0_z, in_corner0_y, in_corner0_x};
  assign vin[1] = {in_corner1_z, in_corner1_y, in_corner1_x};
  assign vin[2] = {in_corner2_z, in_corner2_y, in_corner2_x};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        e_nxt[k][i]  = DWD'($signed(vin[(k+1)%3][i])) - DWD'($signed(vin[k][i]));
        ap_nxt[k][i] = DWD'($signed(pin[i])) - DWD'($signed(vin[k][i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r  <= pin;
    v_r  <= vin;
    e_r  <= e_nxt;
    ap_r <= ap_nxt;
  end

  // corners and point wait for the quotients
  logic [2:0][W-1:0]      p_t5;
  logic [2:0][2:0][W-1:0] v_t5;

  cpt_dly #(.W($bits(p_r) + $bits(v_r)), .N(T5 - T1)) u_dly_pv (
    .clk (clk),
    .d   ({p_r, v_r}),
    .q   ({p_t5, v_t5})
  );

  // ---------------------------------------------------------------------
  // pass 1: normal, segment dots, squared edge lengths
  // ---------------------------------------------------------------------
  logic [2:0][1:0][2*DWD-1:0] np;
  logic [2:0][2:0][2*DWD-1:0] dp_w, lp_w;

  for (genvar i = 0; i < 3; i++) begin : g_norm
    cpt_mul #(.WA(DWD), .WB(DWD)) u_n0 (
      .clk (clk), .a (e_r[0][(i+1)%3]), .b (e_r[1][(i+2)%3]), .p (np[i][0])
    );
    cpt_mul #(.WA(DWD), .WB(DWD)) u_n1 (
      .clk (clk), .a (e_r[0][(i+2)%3]), .b (e_r[1][(i+1)%3]), .p (np[i][1])
    );
  end

  for (genvar k = 0; k < 3; k++) begin : g_seg
    for (genvar i = 0; i < 3; i++) begin : g_cmp
      cpt_mul #(.WA(DWD), .WB(DWD)) u_d (
        .clk (clk), .a (ap_r[k][i]), .b (e_r[k][i]), .p (dp_w[k][i])
      );
      cpt_mul #(.WA(DWD), .WB(DWD)) u_l (
        .clk (clk), .a (e_r[k][i]), .b (e_r[k][i]), .p (lp_w[k][i])
      );
    end
  end

  logic [2:0][NWN-1:0] n_nxt, n_r;
  logic [2:0][DLW-1:0] d_nxt, d_r, l_nxt, l_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_nxt[k] = NWN'($signed(np[k][0])) - NWN'($signed(np[k][1]));
      d_nxt[k] = DLW'($signed(dp_w[k][0])) + DLW'($signed(dp_w[k][1]))
               + DLW'($signed(dp_w[k][2]));
      l_nxt[k] = DLW'($signed(lp_w[k][0])) + DLW'($signed(lp_w[k][1]))
               + DLW'($signed(lp_w[k][2]));
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    d_r <= d_nxt;
    l_r <= l_nxt;
  end

  // segment clamps: at or before the start, or at or past the end
  logic [2:0] lez_c, gel_c, lez_t5, gel_t5;
  logic       nz_c, nz_t4;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lez_c[k] = d_r[k][DLW-1] || (d_r[k] == '0);
      gel_c[k] = $signed(d_r[k]) >= $signed(l_r[k]);
    end
  end

  // zero normal forces the edge answer
  assign nz_c = (n_r == '0);

  cpt_dly #(.W(6), .N(T5 - T2)) u_dly_clamp (
    .clk (clk), .d ({gel_c, lez_c}), .q ({gel_t5, lez_t5})
  );

  cpt_dly #(.W(1), .N(T4 - T2)) u_dly_nz (
    .clk (clk), .d (nz_c), .q (nz_t4)
  );

  logic [2:0][DLW-1:0]      l_t4;
  logic [2:0][2:0][DWD-1:0] e_t2, e_t3, ap_t2, ap_t3;

  cpt_dly #(.W($bits(l_r)), .N(T4 - T2)) u_dly_l (
    .clk (clk), .d (l_r), .q (l_t4)
  );
  cpt_dly #(.W($bits(e_r)), .N(T2 - T1)) u_dly_e2 (
    .clk (clk), .d (e_r), .q (e_t2)
  );
  cpt_dly #(.W($bits(ap_r)), .N(T2 - T1)) u_dly_ap2 (
    .clk (clk), .d (ap_r), .q (ap_t2)
  );

  // ---------------------------------------------------------------------
  // pass 2: edge-plane vectors, squared normal, plane offset
  // ---------------------------------------------------------------------
  logic [2:0][2:0][1:0][NWN+DWD-1:0] cp;
  logic [2:0][2*NWN-1:0]             mp;
  logic [2:0][NWN+DWD-1:0]           qp;

  for (genvar k = 0; k < 3; k++) begin : g_cross
    for (genvar i = 0; i < 3; i++) begin : g_cmp
      cpt_mul #(.WA(NWN), .WB(DWD)) u_c0 (
        .clk (clk), .a (n_r[(i+2)%3]), .b (e_t2[k][(i+1)%3]), .p (cp[k][i][0])
      );
      cpt_mul #(.WA(NWN), .WB(DWD)) u_c1 (
        .clk (clk), .a (n_r[(i+1)%3]), .b (e_t2[k][(i+2)%3]), .p (cp[k][i][1])
      );
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_plane
    cpt_mul #(.WA(NWN), .WB(NWN)) u_m (
      .clk (clk), .a (n_r[i]), .b (n_r[i]), .p (mp[i])
    );
    cpt_mul #(.WA(NWN), .WB(DWD)) u_q (
      .clk (clk), .a (n_r[i]), .b (ap_t2[0][i]), .p (qp[i])
    );
  end

  logic [2:0][2:0][CW-1:0] c_nxt, c_r;
  logic [MW-1:0]           m_nxt, m_r;
  logic [QW-1:0]           q_nxt, q_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        c_nxt[k][i] = CW'($signed(cp[k][i][0])) - CW'($signed(cp[k][i][1]));
      end
    end
    m_nxt = MW'($signed(mp[0])) + MW'($signed(mp[1])) + MW'($signed(mp[2]));
    q_nxt = QW'($signed(qp[0])) + QW'($signed(qp[1])) + QW'($signed(qp[2]));
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
    m_r <= m_nxt;
    q_r <= q_nxt;
  end

  logic [2:0][NWN-1:0] n_t3;
  logic [2:0][DLW-1:0] d_t3;
  logic [MW-1:0]       m_t4;

  cpt_dly #(.W($bits(n_r)), .N(T3 - T2)) u_dly_n3 (
    .clk (clk), .d (n_r), .q (n_t3)
  );
  cpt_dly #(.W($bits(d_r)), .N(T3 - T2)) u_dly_d3 (
    .clk (clk), .d (d_r), .q (d_t3)
  );
  cpt_dly #(.W($bits(ap_t2)), .N(T3 - T2)) u_dly_ap3 (
    .clk (clk), .d (ap_t2), .q (ap_t3)
  );
  cpt_dly #(.W($bits(e_t2)), .N(T3 - T2)) u_dly_e3 (
    .clk (clk), .d (e_t2), .q (e_t3)
  );
  cpt_dly #(.W(MW), .N(T4 - T3)) u_dly_m4 (
    .clk (clk), .d (m_r), .q (m_t4)
  );

  // ---------------------------------------------------------------------
  // pass 3: edge tests and quotient numerators
  // ---------------------------------------------------------------------
  logic [2:0][2:0][CW+DWD-1:0] sp;
  logic [2:0][2:0][NEW-1:0]    nep;
  logic [2:0][NPW-1:0]         npp;

  for (genvar k = 0; k < 3; k++) begin : g_test
    for (genvar i = 0; i < 3; i++) begin : g_cmp
      cpt_mul #(.WA(CW), .WB(DWD)) u_s (
        .clk (clk), .a (c_r[k][i]), .b (ap_t3[k][i]), .p (sp[k][i])
      );
      cpt_mul #(.WA(DLW), .WB(DWD)) u_ne (
        .clk (clk), .a (d_t3[k]), .b (e_t3[k][i]), .p (nep[k][i])
      );
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_pnum
    cpt_mul #(.WA(QW), .WB(NWN)) u_np (
      .clk (clk), .a (q_r), .b (n_t3[i]), .p (npp[i])
    );
  end

  logic [2:0][SW-1:0]       s_nxt, s_r;
  logic [2:0][2:0][NEW-1:0] ne_r;
  logic [2:0][NPW-1:0]      np_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_nxt[k] = SW'($signed(sp[k][0])) + SW'($signed(sp[k][1])) + SW'($signed(sp[k][2]));
    end
  end

  always_ff @(posedge clk) begin
    s_r  <= s_nxt;
    ne_r <= nep;
    np_r <= npp;
  end

  // branch pick, then route edge 0 dividers to the plane projection if inside
  logic                     branch_nxt, branch_r, branch_t7;
  logic [2:0][NPW-1:0]      dn0_nxt, dn0_r;
  logic [MW-1:0]            dd0_nxt, dd0_r;
  logic [1:0][2:0][NEW-1:0] dn12_r;
  logic [1:0][DLW-1:0]      dd12_r;

  always_comb begin
    branch_nxt = nz_t4;
    for (int k = 0; k < 3; k++) begin
      // outside edge k when the test sum is strictly positive
      if (!s_r[k][SW-1] && (s_r[k] != '0)) begin
        branch_nxt = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      dn0_nxt[i] = branch_nxt ? NPW'($signed(ne_r[0][i])) : np_r[i];
    end
    dd0_nxt = branch_nxt ? MW'(l_t4[0]) : m_t4;
  end

  always_ff @(posedge clk) begin
    branch_r  <= branch_nxt;
    dn0_r     <= dn0_nxt;
    dd0_r     <= dd0_nxt;
    dn12_r[0] <= ne_r[1];
    dn12_r[1] <= ne_r[2];
    dd12_r[0] <= l_t4[1];
    dd12_r[1] <= l_t4[2];
  end

  cpt_dly #(.W(1), .N(T7 - T4D)) u_dly_br (
    .clk (clk), .d (branch_r), .q (branch_t7)
  );

  // ---------------------------------------------------------------------
  // dividers: three per edge, edge 0 shared with the projection
  // ---------------------------------------------------------------------
  logic [2:0][2:0][QOW-1:0] qd;

  for (genvar i = 0; i < 3; i++) begin : g_div0
    cpt_div #(.NW(NPW), .DW(MW), .QB(QB)) u_div (
      .clk (clk), .num (dn0_r[i]), .den (dd0_r), .q (qd[0][i])
    );
  end

  for (genvar k = 1; k < 3; k++) begin : g_div12
    for (genvar i = 0; i < 3; i++) begin : g_cmp
      cpt_div #(.NW(NEW), .DW(DLW), .QB(QB)) u_div (
        .clk (clk), .num (dn12_r[k-1][i]), .den (dd12_r[k-1]), .q (qd[k][i])
      );
    end
  end

  // ---------------------------------------------------------------------
  // candidates, projection and saturation
  // ---------------------------------------------------------------------
  function automatic logic [W-1:0] sat_coord(input logic [QOW:0] x);
    logic same;
    same = (&x[QOW:W-1]) || !(|x[QOW:W-1]);
    if (same) begin
      sat_coord = x[W-1:0];
    end else if (x[QOW]) begin
      sat_coord = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  logic [2:0][2:0][W-1:0]   cand_nxt, cand_r, cand_t7;
  logic [2:0][2:0][DWD-1:0] diff_nxt, diff_r;
  logic [2:0][W-1:0]        proj_nxt, proj_r, proj_t7;
  logic [QOW:0]             pw [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (lez_t5[k]) begin
          cand_nxt[k][i] = v_t5[k][i];
        end else if (gel_t5[k]) begin
          cand_nxt[k][i] = v_t5[(k+1)%3][i];
        end else begin
          cand_nxt[k][i] = W'(QOW'($signed(v_t5[k][i])) + $signed(qd[k][i]));
        end
        diff_nxt[k][i] = DWD'($signed(cand_nxt[k][i])) - DWD'($signed(p_t5[i]));
      end
    end
    for (int i = 0; i < 3; i++) begin
      pw[i]       = (QOW+1)'($signed(p_t5[i])) - (QOW+1)'($signed(qd[0][i]));
      proj_nxt[i] = sat_coord(pw[i]);
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    diff_r <= diff_nxt;
    proj_r <= proj_nxt;
  end

  cpt_dly #(.W($bits(cand_r)), .N(T7 - T6)) u_dly_cand (
    .clk (clk), .d (cand_r), .q (cand_t7)
  );
  cpt_dly #(.W($bits(proj_r)), .N(T7 - T6)) u_dly_proj (
    .clk (clk), .d (proj_r), .q (proj_t7)
  );

  // ---------------------------------------------------------------------
  // pass 4: squared distances of the edge candidates
  // ---------------------------------------------------------------------
  logic [2:0][2:0][2*DWD-1:0] sqp;

  for (genvar k = 0; k < 3; k++) begin : g_dist
    for (genvar i = 0; i < 3; i++) begin : g_cmp
      cpt_mul #(.WA(DWD), .WB(DWD)) u_sq (
        .clk (clk), .a (diff_r[k][i]), .b (diff_r[k][i]), .p (sqp[k][i])
      );
    end
  end

  logic [2:0][DSW-1:0] dist_nxt, dist_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dist_nxt[k] = DSW'(sqp[k][0]) + DSW'(sqp[k][1]) + DSW'(sqp[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
  end

  // nearest edge, ties resolved toward the later edge
  logic [1:0]        sel;
  logic [2:0][W-1:0] res_nxt, out_r;

  always_comb begin
    if (dist_r[0] < dist_r[1]) begin
      sel = (dist_r[0] < dist_r[2]) ? 2'd0 : 2'd2;
    end else begin
      sel = (dist_r[1] < dist_r[2]) ? 2'd1 : 2'd2;
    end
    res_nxt = branch_t7 ? cand_t7[sel] : proj_t7;
  end

  always_ff @(posedge clk) begin
    out_r <= res_nxt;
  end

  assign out_nearest_x = out_r[0];
  assign out_nearest_y = out_r[1];
  assign out_nearest_z = out_r[2];

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(T8) out_valid)
    else $error("accepted word did not come out after the pipeline latency");

  a_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, T8))
    else $error("result strobe without a matching accepted word");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule
`default_nettype wire

// ===== rtl/cpt_mul.sv =====
// pipelined signed multiplier, operand b split into MUL_STAGES slices
// depends on cpt_pkg for the stage count
`default_nettype none
module cpt_mul import cpt_pkg::*; #(
  parameter int WA = 8,
  parameter int WB = 8
) (
  input  wire logic                    clk,
  input  wire logic signed [WA-1:0]    a,
  input  wire logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0]      p
);

  localparam int S  = MUL_STAGES;
  localparam int CH = (WB + S - 1) / S;
  localparam int BW = S * CH;
  localparam int PW = WA + WB;

  logic signed [WA-1:0] a_r   [S];
  logic signed [BW-1:0] b_r   [S];
  logic signed [PW-1:0] acc_r [S];

  for (genvar j = 0; j < S; j++) begin : g_stage
    logic signed [WA-1:0] a_in;
    logic signed [BW-1:0] b_in;
    logic signed [PW-1:0] acc_in;
    logic signed [PW-1:0] part;
    logic signed [PW-1:0] acc_nxt;

    if (j == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = BW'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[j-1];
      assign b_in   = b_r[j-1];
      assign acc_in = acc_r[j-1];
    end

    // top slice carries the sign, lower slices are unsigned
    if (j == S - 1) begin : g_top
      assign part = PW'(a_in) * PW'($signed(b_in[BW-1 -: CH]));
    end else begin : g_low
      assign part = PW'(a_in) * PW'($signed({1'b0, b_in[j*CH +: CH]}));
    end

    assign acc_nxt = acc_in + (part <<< (j * CH));

    always_ff @(posedge clk) begin
      a_r[j]   <= a_in;
      b_r[j]   <= b_in;
      acc_r[j] <= acc_nxt;
    end
  end

  assign p = acc_r[S-1];

endmodule
`default_nettype wire

// ===== rtl/cpt_div.sv =====
// pipelined restoring divider, one quotient bit per stage, rounds half away
// standalone; used by the top level for the segment and plane quotients
`default_nettype none
module cpt_div #(
  parameter int NW = 16,
  parameter int DW = 8,
  parameter int QB = 8
) (
  input  wire logic                 clk,
  input  wire logic signed [NW-1:0] num,
  input  wire logic [DW-1:0]        den,
  output logic signed [QB+1:0]      q
);

  localparam int RW = DW + 1;

  logic [NW-1:0] mag;
  logic          neg_r [QB+1];
  logic [QB-1:0] lo_r  [QB+1];
  logic [RW-1:0] rem_r [QB+1];
  logic [QB-1:0] quo_r [QB+1];
  logic [DW-1:0] den_r [QB+1];
  logic          rnd;
  logic [QB+1:0] qm;
  logic [QB+1:0] q_r;
  logic [QB+1:0] q_nxt;

  assign mag = num[NW-1] ? NW'(-num) : NW'(num);

  always_ff @(posedge clk) begin
    neg_r[0] <= num[NW-1];
    lo_r[0]  <= mag[QB-1:0];
    rem_r[0] <= RW'(mag >> QB);
    quo_r[0] <= '0;
    den_r[0] <= den;
  end

  for (genvar s = 1; s <= QB; s++) begin : g_step
    logic [RW-1:0] t;
    logic          ge;
    logic [RW-1:0] rem_nxt;

    assign t       = {rem_r[s-1][DW-1:0], lo_r[s-1][QB-s]};
    assign ge      = t >= {1'b0, den_r[s-1]};
    assign rem_nxt = ge ? t - {1'b0, den_r[s-1]} : t;

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      quo_r[s] <= {quo_r[s-1][QB-2:0], ge};
      lo_r[s]  <= lo_r[s-1];
      neg_r[s] <= neg_r[s-1];
      den_r[s] <= den_r[s-1];
    end
  end

  // round on twice the remainder, then restore the sign
  assign rnd   = {rem_r[QB], 1'b0} >= {2'b00, den_r[QB]};
  assign qm    = {2'b00, quo_r[QB]} + (QB+2)'(rnd);
  assign q_nxt = neg_r[QB] ? -qm : qm;

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ===== rtl/cpt_dly.sv =====
// fixed-length delay line that keeps operands in step with the pipeline
// standalone
`default_nettype none
module cpt_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] d,
  output logic [W-1:0]      q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    sr_r[0] <= d;
    for (int j = 1; j < N; j++) begin
      sr_r[j] <= sr_r[j-1];
    end
  end

  assign q = sr_r[N-1];

endmodule
`default_nettype wire

// ===== bench/closest_point_checker.sv =====
// checker for the closest-point-on-triangle block: watches the query and answer words
// depends on nothing but the block's ports; keeps its own exact-arithmetic predictor
module closest_point_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire logic signed [31:0] in_corner0_x,
  input  wire logic signed [31:0] in_corner0_y,
  input  wire logic signed [31:0] in_corner0_z,
  input  wire logic signed [31:0] in_corner1_x,
  input  wire logic signed [31:0] in_corner1_y,
  input  wire logic signed [31:0] in_corner1_z,
  input  wire logic signed [31:0] in_corner2_x,
  input  wire logic signed [31:0] in_corner2_y,
  input  wire logic signed [31:0] in_corner2_z,
  input  wire logic               out_valid,
  input  wire logic signed [31:0] out_nearest_x,
  input  wire logic signed [31:0] out_nearest_y,
  input  wire logic signed [31:0] out_nearest_z,
  output int                      fail_count,
  output int                      pending_count
);

  typedef logic signed [255:0] wide_t;
  typedef struct packed {
    wide_t x;
    wide_t y;
    wide_t z;
  } vec3_t;
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  point_t nearest_q[$];

  function automatic vec3_t vec_sub(vec3_t a, vec3_t b);
    vec3_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic wide_t vec_dot(vec3_t a, vec3_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic vec3_t vec_cross(vec3_t a, vec3_t b);
    vec3_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  // rounds to nearest, ties away from zero; den > 0
  function automatic wide_t div_round(wide_t num, wide_t den);
    wide_t mag, q, rem;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    rem = mag % den;
    if (2 * rem >= den) q = q + 1;
    return (num < 0) ? -q : q;
  endfunction

  function automatic vec3_t clamp_to_edge(vec3_t a, vec3_t e, vec3_t p);
    wide_t d, len2;
    vec3_t r;
    d = vec_dot(vec_sub(p, a), e);
    len2 = vec_dot(e, e);
    if (d <= 0) return a;
    if (d >= len2) begin
      r.x = a.x + e.x;
      r.y = a.y + e.y;
      r.z = a.z + e.z;
      return r;
    end
    r.x = a.x + div_round(e.x * d, len2);
    r.y = a.y + div_round(e.y * d, len2);
    r.z = a.z + div_round(e.z * d, len2);
    return r;
  endfunction

  function automatic logic signed [31:0] clip32(wide_t v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic point_t nearest_on_triangle(vec3_t p, vec3_t v0, vec3_t v1, vec3_t v2);
    vec3_t e01, e12, e20, n, c0, c1, c2, r;
    wide_t d0, d1, d2, q, m;
    logic edge_case;
    point_t res;
    e01 = vec_sub(v1, v0);
    e12 = vec_sub(v2, v1);
    e20 = vec_sub(v0, v2);
    n = vec_cross(e01, e12);
    edge_case = (n.x == 0 && n.y == 0 && n.z == 0)
             || vec_dot(vec_cross(e01, n), vec_sub(p, v0)) > 0
             || vec_dot(vec_cross(e12, n), vec_sub(p, v1)) > 0
             || vec_dot(vec_cross(e20, n), vec_sub(p, v2)) > 0;
    if (edge_case) begin
      c0 = clamp_to_edge(v0, e01, p);
      c1 = clamp_to_edge(v1, e12, p);
      c2 = clamp_to_edge(v2, e20, p);
      d0 = vec_dot(vec_sub(c0, p), vec_sub(c0, p));
      d1 = vec_dot(vec_sub(c1, p), vec_sub(c1, p));
      d2 = vec_dot(vec_sub(c2, p), vec_sub(c2, p));
      if (d0 < d1) r = (d0 < d2) ? c0 : c2;
      else r = (d1 < d2) ? c1 : c2;
    end else begin
      q = vec_dot(vec_sub(p, v0), n);
      m = vec_dot(n, n);
      r.x = p.x - div_round(n.x * q, m);
      r.y = p.y - div_round(n.y * q, m);
      r.z = p.z - div_round(n.z * q, m);
    end
    res.x = clip32(r.x);
    res.y = clip32(r.y);
    res.z = clip32(r.z);
    return res;
  endfunction

  function automatic vec3_t widen(logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [31:0] z);
    vec3_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    return r;
  endfunction

  assign pending_count = nearest_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    point_t want;
    if (rst_n && start && !busy)
      nearest_q.push_back(nearest_on_triangle(
        widen(in_point_x, in_point_y, in_point_z),
        widen(in_corner0_x, in_corner0_y, in_corner0_z),
        widen(in_corner1_x, in_corner1_y, in_corner1_z),
        widen(in_corner2_x, in_corner2_y, in_corner2_z)));
    if (rst_n && out_valid) begin
      if (nearest_q.size() == 0) begin
        fail_count <= fail_count + 1;
        $display("%0t: unexpected answer word %0d %0d %0d", $time,
                 out_nearest_x, out_nearest_y, out_nearest_z);
      end else begin
        want = nearest_q.pop_front();
        if (want != {out_nearest_x, out_nearest_y, out_nearest_z}) begin
          fail_count <= fail_count + 1;
          $display("%0t: mismatch expected %0d %0d %0d actual %0d %0d %0d", $time,
                   want.x, want.y, want.z, out_nearest_x, out_nearest_y, out_nearest_z);
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
// top of the bench: clock, reset, query stimulus and the verdict
// depends on closest_point_on_triangle_3d and closest_point_checker
module testbench;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic signed [31:0] pt [3];
  logic signed [31:0] c0 [3];
  logic signed [31:0] c1 [3];
  logic signed [31:0] c2 [3];
  logic        out_valid;
  logic signed [31:0] out_nearest_x, out_nearest_y, out_nearest_z;
  int          fail_count, pending_count;

  localparam int N_RANDOM = 630;
  localparam int TAIL_NO_IDLE = 100;  // last words go back to back
  localparam int DRAIN_CYCLES = 120;

  closest_point_on_triangle_3d u_dut (
    .clk, .rst_n, .start, .busy,
    .in_point_x(pt[0]), .in_point_y(pt[1]), .in_point_z(pt[2]),
    .in_corner0_x(c0[0]), .in_corner0_y(c0[1]), .in_corner0_z(c0[2]),
    .in_corner1_x(c1[0]), .in_corner1_y(c1[1]), .in_corner1_z(c1[2]),
    .in_corner2_x(c2[0]), .in_corner2_y(c2[1]), .in_corner2_z(c2[2]),
    .out_valid, .out_nearest_x, .out_nearest_y, .out_nearest_z
  );

  closest_point_checker u_checker (
    .clk, .rst_n, .start, .busy,
    .in_point_x(pt[0]), .in_point_y(pt[1]), .in_point_z(pt[2]),
    .in_corner0_x(c0[0]), .in_corner0_y(c0[1]), .in_corner0_z(c0[2]),
    .in_corner1_x(c1[0]), .in_corner1_y(c1[1]), .in_corner1_z(c1[2]),
    .in_corner2_x(c2[0]), .in_corner2_y(c2[1]), .in_corner2_z(c2[2]),
    .out_valid, .out_nearest_x, .out_nearest_y, .out_nearest_z,
    .fail_count, .pending_count
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the pipeline hangs
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // drives one query word and holds it until the block takes it
  task automatic send_word(logic signed [31:0] w [12]);
    for (int i = 0; i < 3; i++) begin
      pt[i] <= w[i];
      c0[i] <= w[3 + i];
      c1[i] <= w[6 + i];
      c2[i] <= w[9 + i];
    end
    start <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 7)) @(posedge clk);
  endtask

  // small values land inside often; full range hits saturation and every bit
  function automatic logic signed [31:0] rand_coord(int mode);
    logic signed [31:0] v;
    case (mode)
      0: v = $urandom();
      1: v = $signed($urandom_range(0, 2097151)) - 1048576;
      2: v = $signed($urandom_range(0, 255)) - 128;
      default: v = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
    endcase
    return v;
  endfunction

  initial begin
    logic signed [31:0] w [12];
    logic signed [31:0] mx, mn;
    int mode, shape;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    rst_n = 1'b0;
    start = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pt[i] = 0; c0[i] = 0; c1[i] = 0; c2[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all zero, point inside, vertex regions, degenerate shapes, extremes
    w = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_word(w);
    w = '{65536, 65536, 131072, 0, 0, 0, 262144, 0, 0, 0, 262144, 0};
    send_word(w);
    w = '{-65536, -65536, 5, 0, 0, 0, 262144, 0, 0, 0, 262144, 0};
    send_word(w);
    w = '{400000, -3, 7, 0, 0, 0, 262144, 0, 0, 0, 262144, 0};
    send_word(w);
    w = '{200000, 200000, -9, 0, 0, 0, 262144, 0, 0, 0, 262144, 0};
    send_word(w);
    w = '{9, 9, 9, 1, 1, 1, 1, 1, 1, 1, 1, 1};
    send_word(w);
    w = '{5, -7, 3, 0, 0, 0, 10, 10, 10, 20, 20, 20};
    send_word(w);
    w = '{5, 5, 5, 0, 0, 0, 0, 0, 0, 30, 0, 0};
    send_word(w);
    w = '{1, 1, 0, 0, 0, 0, 2, 0, 0, 0, 2, 0};
    send_word(w);
    w = '{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx};
    send_word(w);
    w = '{mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn};
    send_word(w);
    w = '{mx, mx, mx, mn, mn, mn, mx, mn, mn, mn, mx, mn};
    send_word(w);
    w = '{mn, mx, mn, mx, mn, mx, mn, mn, mx, mx, mx, mn};
    send_word(w);
    w = '{0, 0, mx, mn, mn, 0, mx, mn, 0, 0, mx, 0};
    send_word(w);
    w = '{0, 0, mn, mn, mn, 0, mx, mn, 0, 0, mx, 0};
    send_word(w);
    w = '{mx, 0, 0, 0, mn, mn, 0, mx, mn, 0, 0, mx};
    send_word(w);
    w = '{-1, -1, -1, 0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_word(w);
    w = '{1, 1, 1, 0, 0, 0, 0, 1, 0, 1, 0, 0};
    send_word(w);
    start <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 3) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
      foreach (w[i]) w[i] = rand_coord(mode);
      shape = $urandom_range(0, 9);
      // some triangles collapse to a segment or a point
      if (shape == 0) begin
        for (int i = 0; i < 3; i++) w[9 + i] = w[6 + i];
      end else if (shape == 1) begin
        for (int i = 0; i < 3; i++) begin
          w[6 + i] = w[3 + i];
          w[9 + i] = w[3 + i];
        end
      end else if (shape == 2) begin
        for (int i = 0; i < 3; i++) w[9 + i] = w[3 + i] + 2 * (w[6 + i] - w[3 + i]);
      end
      send_word(w);
      if (n < N_RANDOM - TAIL_NO_IDLE && $urandom_range(0, 3) == 0) idle_burst();
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cpt_pkg.sv
rtl/cpt_mul.sv
rtl/cpt_div.sv
rtl/cpt_dly.sv
rtl/closest_point_on_triangle_3d.sv
bench/closest_point_checker.sv
bench/testbench.sv
